### design/ovle_pkg.sv
// Shared types and operation codes for the ordered value list engine.
// No dependencies; compiled first.
package ovle_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_FIND   = 2'd1;
  localparam op_t OP_DELETE = 2'd2;
  localparam op_t OP_INSERT = 2'd3;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    op_t                       operation;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } cmd_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

endpackage

### design/ovle_req_if.sv
// Request channel: valid/ready handshake carrying one operation word.
// Depends on nothing.
interface ovle_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] value;
  logic [4:0]        position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

### design/ovle_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on nothing.
interface ovle_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [4:0] entry_count;

  modport source (output valid, output ok, output entry_count, input ready);
  modport sink   (input valid, input ok, input entry_count, output ready);
endinterface

### design/ovle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ovle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ovle_ctrl.sv
// Sequencer for the list operations: walks the entry RAM one word per cycle
// through a single compare/index unit. Depends on ovle_pkg and ovle_ram.
module ovle_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ovle_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output ovle_pkg::result_t result
);
  import ovle_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int RW   = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_PUT   = 2'd3;

  logic [1:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  op_t                op, op_next;
  logic [VALUE_W-1:0] value, value_next;
  logic [AW-1:0]      pos, pos_next;
  logic [CW-1:0]      rd_idx, rd_idx_next;
  logic [AW-1:0]      rd_src, rd_src_next;
  logic               rd_live, rd_live_next;
  logic [CW-1:0]      keep, keep_next;
  logic               hit, hit_next;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [VALUE_W-1:0] wdata, rdata;

  logic               res_ok;
  logic [CW-1:0]      res_count;
  logic [RW-1:0]      res_wide;

  logic [CMPW-1:0]    pos_w, cnt_w;
  logic               ins_legal;
  logic               match;

  ovle_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pos_w     = CMPW'(cmd.position);
  assign cnt_w     = CMPW'(count);
  assign ins_legal = (pos_w != '0) && (count != '0) && (count < CW'(DEPTH)) &&
                     (pos_w <= cnt_w);
  assign match     = (rdata == value);

  always_comb begin
    state_next   = state;
    count_next   = count;
    op_next      = op;
    value_next   = value;
    pos_next     = pos;
    rd_idx_next  = rd_idx;
    rd_src_next  = rd_src;
    rd_live_next = 1'b0;
    keep_next    = keep;
    hit_next     = hit;
    we           = 1'b0;
    waddr        = '0;
    wdata        = value;
    raddr        = rd_idx[AW-1:0];
    done         = 1'b0;
    res_ok       = 1'b0;
    res_count    = count;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = cmd.operation;
          value_next = cmd.value;
          pos_next   = pos_w[AW-1:0];
          unique case (cmd.operation) inside
            OP_APPEND: begin
              done = 1'b1;
              if (count < CW'(DEPTH)) begin
                we         = 1'b1;
                waddr      = count[AW-1:0];
                wdata      = cmd.value;
                count_next = count + 1'b1;
                res_ok     = 1'b1;
                res_count  = count + 1'b1;
              end
            end
            OP_FIND, OP_DELETE: begin
              if (count == '0) begin
                done = 1'b1;
              end else begin
                state_next  = S_SCAN;
                rd_idx_next = '0;
                keep_next   = '0;
                hit_next    = 1'b0;
              end
            end
            OP_INSERT: begin
              if (!ins_legal) begin
                done = 1'b1;
              end else if (pos_w == cnt_w) begin
                // insert at the tail: no entries to move
                we         = 1'b1;
                waddr      = pos_w[AW-1:0];
                wdata      = cmd.value;
                count_next = count + 1'b1;
                done       = 1'b1;
                res_ok     = 1'b1;
                res_count  = count + 1'b1;
              end else begin
                state_next  = S_SHIFT;
                rd_idx_next = count - 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_idx < count) begin
          rd_idx_next  = rd_idx + 1'b1;
          rd_live_next = 1'b1;
        end
        if (rd_live) begin
          if (match) begin
            hit_next = 1'b1;
          end else if (op == OP_DELETE) begin
            // compact survivors toward the head
            we        = 1'b1;
            waddr     = keep[AW-1:0];
            wdata     = rdata;
            keep_next = keep + 1'b1;
          end
          if (rd_idx == count) begin
            done       = 1'b1;
            state_next = S_IDLE;
            res_ok     = hit | match;
            if (op == OP_DELETE) begin
              count_next = keep_next;
              res_count  = keep_next;
            end
          end
        end
      end

      S_SHIFT: begin
        if (rd_idx >= CW'(pos)) begin
          rd_idx_next  = rd_idx - 1'b1;
          rd_src_next  = rd_idx[AW-1:0];
          rd_live_next = 1'b1;
        end
        if (rd_live) begin
          we    = 1'b1;
          waddr = rd_src + 1'b1;
          wdata = rdata;
          if (rd_src == pos) begin
            state_next = S_PUT;
          end
        end
      end

      S_PUT: begin
        we         = 1'b1;
        waddr      = pos;
        wdata      = value;
        count_next = count + 1'b1;
        done       = 1'b1;
        res_ok     = 1'b1;
        res_count  = count + 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy               = (state != S_IDLE);
  assign res_wide           = RW'(res_count);
  assign result.ok          = res_ok;
  assign result.entry_count = res_wide[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_live <= 1'b0;
      hit     <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_live <= rd_live_next;
      hit     <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    value  <= value_next;
    pos    <= pos_next;
    rd_idx <= rd_idx_next;
    rd_src <= rd_src_next;
    keep   <= keep_next;
  end

endmodule

### design/ordered_value_list_engine.sv
// Top level of the ordered value list engine: request/response handshake and
// result register. Depends on ovle_pkg, ovle_req_if, ovle_rsp_if, ovle_ctrl.
//
// Keeps an ordered list of up to DEPTH signed 32-bit entries in a single
// RAM (one write port, one registered read port; contents are undefined until
// written, so no clearing pass is needed after reset). Each request word
// carries an operation: append at the tail, find, delete every matching entry
// (survivors keep their order), or insert at a position p (1..count) which
// places the value at index p and moves later entries up. Each request gives
// exactly one response word: ok plus the entry count afterwards (low 5 bits).
// Timing: append, rejected operations and insert at the tail finish in the
// accept cycle; find and delete stream every entry through the compare unit;
// insert moves entries p..count-1 up by one, then writes the value. The one
// RAM read port is streamed one entry per cycle through a single compare
// unit. req.ready is low while an operation is in progress; a new word is
// taken once the response register is empty or being drained.
module ordered_value_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  ovle_req_if.sink   req,
  ovle_rsp_if.source rsp
);
  import ovle_pkg::*;

  cmd_t    cmd;
  result_t result;
  result_t rsp_word;
  logic    start;
  logic    busy;
  logic    done;
  logic    rsp_valid;

  assign cmd.operation = req.operation;
  assign cmd.value     = req.value;
  assign cmd.position  = req.position;

  // one word in flight: response register must be free by the time we finish
  assign req.ready = !busy && (!rsp_valid || rsp.ready);
  assign start     = req.valid && req.ready;

  ovle_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // response register; a fresh result wins over a drain in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_word <= result;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_word.ok;
  assign rsp.entry_count = rsp_word.entry_count;

endmodule
